>>> rtl/phc_pkg.sv
// Shared types and constants for the IPv4 packet header classifier.
// No dependencies; the parser, queue, classifier and top level import this package.
`default_nettype none

package phc_pkg;

  // Depth of the frame summary queue between parser and classifier
  localparam int unsigned QUEUE_DEPTH = 2;

  // IPv4 protocol numbers
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // TCP flag bit positions
  localparam int unsigned BIT_FIN = 0;
  localparam int unsigned BIT_SYN = 1;
  localparam int unsigned BIT_RST = 2;
  localparam int unsigned BIT_ACK = 4;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [5:0] MIN_IHL_BYTES = 6'd20;

  typedef enum logic [1:0] {
    FLAG_SF,
    FLAG_S0,
    FLAG_RSTO,
    FLAG_REJ
  } flag_code_t;

  typedef enum logic [2:0] {
    SVC_FTP,
    SVC_SSH,
    SVC_SMTP,
    SVC_DNS,
    SVC_HTTP,
    SVC_HTTPS
  } service_code_t;

  // Everything the parser captured for one frame
  typedef struct packed {
    logic [16:0] cap_length;
    logic [7:0]  header_words;
    logic [31:0] ip_source;
    logic [31:0] ip_destination;
    logic [7:0]  protocol_byte;
    logic [31:0] ports_seen;
    logic [7:0]  tcp_flag_byte;
    logic [15:0] wire_length;
  } frame_summary_t;

endpackage

`default_nettype wire

>>> rtl/phc_ifs.sv
// Valid/ready channel interfaces: frame byte input and classification result.
// No dependencies.
`default_nettype none

interface phc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] wire_length;

  modport source (output valid, data_byte, last_byte, wire_length, input ready);
  modport sink   (input valid, data_byte, last_byte, wire_length, output ready);
endinterface

interface phc_out_if;
  logic        valid;
  logic        ready;
  logic        kept;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] l4_sport;
  logic [15:0] l4_dport;
  logic        is_udp;
  logic [1:0]  flag_code;
  logic [2:0]  service_code;
  logic [15:0] frame_length;
  logic [31:0] accepted_total;
  logic [31:0] error_total;

  modport source (
    output valid, kept, source_address, destination_address, l4_sport,
           l4_dport, is_udp, flag_code, service_code, frame_length,
           accepted_total, error_total,
    input  ready
  );
  modport sink (
    input  valid, kept, source_address, destination_address, l4_sport,
           l4_dport, is_udp, flag_code, service_code, frame_length,
           accepted_total, error_total,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/phc_parser.sv
// Front end: byte-serial frame parser that captures header fields.
// Depends on phc_pkg and phc_in_if; emits one frame summary per last byte.
`default_nettype none

module phc_parser import phc_pkg::*; #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  phc_in_if.sink         in_ch,
  output logic           sum_valid,
  input  logic           sum_ready,
  output frame_summary_t sum_data
);

  localparam logic [16:0] BASE = 17'(LINK_HEADER_BYTES);

  logic [15:0] pos_r;
  logic [7:0]  hw_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [7:0]  proto_r;
  logic [31:0] ports_r;
  logic [7:0]  flags_r;

  logic [7:0]  hw_nxt;
  logic [31:0] src_nxt;
  logic [31:0] dst_nxt;
  logic [7:0]  proto_nxt;
  logic [31:0] ports_nxt;
  logic [7:0]  flags_nxt;
  logic [16:0] pos_x;
  logic [16:0] tstart;
  logic        accept;

  assign in_ch.ready = sum_ready;
  assign accept      = in_ch.valid && sum_ready;

  // Field capture for the byte at the current position
  always_comb begin
    pos_x     = {1'b0, pos_r};
    hw_nxt    = (pos_x == BASE) ? in_ch.data_byte : hw_r;
    proto_nxt = (pos_x == BASE + 17'd9) ? in_ch.data_byte : proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ports_nxt = ports_r;
    flags_nxt = flags_r;
    if (pos_x >= BASE + 17'd12 && pos_x <= BASE + 17'd15) begin
      src_nxt = {src_r[23:0], in_ch.data_byte};
    end
    if (pos_x >= BASE + 17'd16 && pos_x <= BASE + 17'd19) begin
      dst_nxt = {dst_r[23:0], in_ch.data_byte};
    end
    // transport header starts after the IPv4 header, using this byte's length
    tstart = BASE + {11'd0, hw_nxt[3:0], 2'b00};
    if (pos_x >= tstart && pos_x <= tstart + 17'd3) begin
      ports_nxt = {ports_r[23:0], in_ch.data_byte};
    end
    if (pos_x == tstart + 17'd13) begin
      flags_nxt = in_ch.data_byte;
    end
  end

  // Summary pushed on the last byte
  always_comb begin
    sum_valid               = accept && in_ch.last_byte;
    sum_data.cap_length     = pos_x + 17'd1;
    sum_data.header_words   = hw_nxt;
    sum_data.ip_source      = src_nxt;
    sum_data.ip_destination = dst_nxt;
    sum_data.protocol_byte  = proto_nxt;
    sum_data.ports_seen     = ports_nxt;
    sum_data.tcp_flag_byte  = flags_nxt;
    sum_data.wire_length    = in_ch.wire_length;
  end

  // Per-frame state; cleared after each frame
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.last_byte)) begin
      pos_r   <= '0;
      hw_r    <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      proto_r <= '0;
      ports_r <= '0;
      flags_r <= '0;
    end else if (accept) begin
      pos_r   <= (pos_r != 16'hffff) ? pos_r + 16'd1 : pos_r;
      hw_r    <= hw_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      proto_r <= proto_nxt;
      ports_r <= ports_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/phc_queue.sv
// Small FIFO of frame summaries between parser and classifier.
// Depends on phc_pkg for the entry type and depth.
`default_nettype none

module phc_queue import phc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  frame_summary_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output frame_summary_t pop_data
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  frame_summary_t entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/phc_classify.sv
// Back end: checks a frame summary, classifies flags and service, keeps totals.
// Depends on phc_pkg and phc_out_if; drives the registered result channel.
`default_nettype none

module phc_classify import phc_pkg::*; #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           sum_valid,
  output logic           sum_ready,
  input  frame_summary_t sum_data,
  phc_out_if.source      out_ch
);

  localparam logic [16:0] BASE = 17'(LINK_HEADER_BYTES);

  function automatic logic noise_address(input logic [31:0] a);
    logic [7:0] first;
    logic [7:0] second;
    first  = a[31:24];
    second = a[23:16];
    return (first == 8'd0) || (first == 8'd127) || (first >= 8'd224) ||
           (first == 8'd169 && second == 8'd254);
  endfunction

  function automatic flag_code_t flag_class(input logic [7:0] f);
    flag_code_t code;
    if (f[BIT_SYN] && !f[BIT_ACK]) begin
      code = FLAG_S0;
    end else if (f[BIT_RST]) begin
      code = FLAG_RSTO;
    end else if (f[BIT_FIN] || f[BIT_ACK]) begin
      code = FLAG_SF;
    end else begin
      code = FLAG_REJ;
    end
    return code;
  endfunction

  function automatic service_code_t service_class(input logic [15:0] port);
    service_code_t svc;
    case (port) inside
      16'd20, 16'd21: svc = SVC_FTP;
      16'd22: svc = SVC_SSH;
      16'd25, 16'd110, 16'd143, 16'd465, 16'd587, 16'd993, 16'd995: svc = SVC_SMTP;
      16'd53: svc = SVC_DNS;
      16'd443: svc = SVC_HTTPS;
      default: svc = SVC_HTTP;
    endcase
    return svc;
  endfunction

  logic        out_valid_r;
  logic        kept_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic        udp_r;
  flag_code_t  flag_r;
  service_code_t svc_r;
  logic [15:0] len_r;
  logic [31:0] kept_cnt_r;
  logic [31:0] err_cnt_r;
  logic [31:0] kept_cnt_nxt;
  logic [31:0] err_cnt_nxt;

  logic        pop;
  logic [16:0] ihl_bytes;
  logic [16:0] hdr_end;
  logic        is_tcp;
  logic        is_udp;
  logic        keep;
  flag_code_t  flag;

  assign sum_ready = !out_valid_r || out_ch.ready;
  assign pop       = sum_valid && sum_ready;

  // Frame checks and classification
  always_comb begin
    ihl_bytes = {11'd0, sum_data.header_words[3:0], 2'b00};
    hdr_end   = BASE + ihl_bytes;
    is_tcp    = (sum_data.protocol_byte == PROTO_TCP);
    is_udp    = (sum_data.protocol_byte == PROTO_UDP);
    keep      = 1'b1;
    if (sum_data.cap_length < BASE + 17'd20) begin
      keep = 1'b0;
    end
    if (sum_data.header_words[7:4] != IP_VERSION_4 ||
        ihl_bytes < {11'd0, MIN_IHL_BYTES} || sum_data.cap_length < hdr_end) begin
      keep = 1'b0;
    end
    if (noise_address(sum_data.ip_source) || noise_address(sum_data.ip_destination)) begin
      keep = 1'b0;
    end
    if (!is_tcp && !is_udp) begin
      keep = 1'b0;
    end
    // transport header length: 20 bytes TCP, 8 bytes UDP
    if (is_tcp && sum_data.cap_length < hdr_end + 17'd20) begin
      keep = 1'b0;
    end
    if (is_udp && sum_data.cap_length < hdr_end + 17'd8) begin
      keep = 1'b0;
    end
    flag         = is_tcp ? flag_class(sum_data.tcp_flag_byte) : FLAG_SF;
    kept_cnt_nxt = keep ? kept_cnt_r + 32'd1 : kept_cnt_r;
    err_cnt_nxt  = (keep && flag != FLAG_SF) ? err_cnt_r + 32'd1 : err_cnt_r;
  end

  // Control and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      kept_cnt_r  <= '0;
      err_cnt_r   <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        kept_cnt_r  <= kept_cnt_nxt;
        err_cnt_r   <= err_cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register; dropped frames give zero fields apart from the wire length
  always_ff @(posedge clk) begin
    if (pop) begin
      kept_r  <= keep;
      src_r   <= keep ? sum_data.ip_source : '0;
      dst_r   <= keep ? sum_data.ip_destination : '0;
      sport_r <= keep ? sum_data.ports_seen[31:16] : '0;
      dport_r <= keep ? sum_data.ports_seen[15:0] : '0;
      udp_r   <= keep && is_udp;
      flag_r  <= keep ? flag : FLAG_SF;
      svc_r   <= keep ? service_class(sum_data.ports_seen[15:0]) : SVC_FTP;
      len_r   <= sum_data.wire_length;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.kept                = kept_r;
  assign out_ch.source_address      = src_r;
  assign out_ch.destination_address = dst_r;
  assign out_ch.l4_sport            = sport_r;
  assign out_ch.l4_dport            = dport_r;
  assign out_ch.is_udp              = udp_r;
  assign out_ch.flag_code           = flag_r;
  assign out_ch.service_code        = svc_r;
  assign out_ch.frame_length        = len_r;
  assign out_ch.accepted_total      = kept_cnt_r;
  assign out_ch.error_total         = err_cnt_r;

endmodule

`default_nettype wire

>>> rtl/ipv4_packet_header_classifier_unit.sv
// IPv4 packet header classifier, top level.
// Usage:
//   in_ch carries one captured Ethernet frame byte per transaction, in wire
//   order, with last_byte on the final byte and wire_length sampled there.
//   The first LINK_HEADER_BYTES bytes are skipped as link header.
//   out_ch carries one result per frame: kept flag, addresses, ports,
//   protocol, TCP flag class, service class, wire length and the wrapping
//   kept/error totals. Dropped frames give zero classification fields.
// Throughput: one byte per cycle sustained; in_ch.ready stays high while the
//   summary queue has room. Each frame yields at most one summary per cycle.
// Result path: the summary of the last accepted byte passes through the summary
//   queue register, then the result register, which raises out_ch.valid.
// Stalls: while out_ch.ready is low the result register holds, the classifier
//   stops, and the two-entry summary queue fills; only when it is full does
//   in_ch.ready drop.
// Reset: rst_n (synchronous, active low) clears the byte position, captured
//   fields, queue and totals; the block is ready on the first cycle after.
// Depends on phc_pkg, phc_ifs, phc_parser, phc_queue and phc_classify.
`default_nettype none

module ipv4_packet_header_classifier_unit import phc_pkg::*; #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  phc_in_if.sink    in_ch,
  phc_out_if.source out_ch
);

  frame_summary_t push_data;
  frame_summary_t head_data;
  logic           push_valid;
  logic           push_ready;
  logic           head_valid;
  logic           head_ready;

  phc_parser #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .sum_valid(push_valid),
    .sum_ready(push_ready),
    .sum_data (push_data)
  );

  phc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (head_valid),
    .pop_ready (head_ready),
    .pop_data  (head_data)
  );

  phc_classify #(
    .LINK_HEADER_BYTES(LINK_HEADER_BYTES)
  ) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .sum_valid(head_valid),
    .sum_ready(head_ready),
    .sum_data (head_data),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // A frame summary is only pushed when the queue can take it
  assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("summary pushed into full queue");

  // A new result appears only after a summary was popped
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(head_valid && head_ready))
    else $error("result without popped summary");

  // Dropped frames carry zero classification fields
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.kept) |->
      (out_ch.source_address == '0 && out_ch.l4_dport == '0 &&
       out_ch.flag_code == '0 && !out_ch.is_udp))
    else $error("dropped frame with nonzero fields");
`endif

endmodule

`default_nettype wire
